[hdl/assert_macros.svh]
// Assertion macros for the sorted key queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SKQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define SKQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SKQ_ASSERT_ALWAYS(lbl, expr)
`define SKQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/skq_pkg.sv]
// Types, codes and helpers shared by the sorted key queue modules.
package skq_pkg;
    localparam int DEPTH_DEF    = 32;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;
    localparam int CNT_IN_W     = 11;

    localparam logic CFG_ALLOW_DUPS  = 1'b0;
    localparam logic CFG_APPEND_DUPS = 1'b1;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_POP       = 3'd1,
        OP_PEEK      = 3'd2,
        OP_FIND      = 3'd3,
        OP_DEL_FIRST = 3'd4,
        OP_DEL_ALL   = 3'd5,
        OP_CLEAR     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OSEL_NONE  = 2'd0,
        OSEL_HEAD  = 2'd1,
        OSEL_MATCH = 2'd2
    } t_osel;

    typedef struct packed {
        logic    load;
        logic    ins;
        logic    append;
        logic    rm_head;
        logic    rm_match;
        logic    clr;
        logic    res_we;
        t_status status;
        t_osel   osel;
        logic    cnt_removed;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic any_match;
        logic full;
        logic empty;
        logic removed_zero;
    } t_stat;

    function automatic logic [5:0] sat_count(input logic [CNT_IN_W-1:0] n);
        logic [5:0] r;
        if (n > CNT_IN_W'(63)) begin
            r = 6'd63;
        end else begin
            r = n[5:0];
        end
        return r;
    endfunction
endpackage

[hdl/sorted_key_queue.sv]
// Top level of the sorted key queue: sequencer plus entry cell datapath.
//
// Holds up to DEPTH key/tag entries in ascending unsigned key order, one
// register cell per entry with its own comparator. An operation is taken when
// start is high and busy is low; busy then stays high while the operation
// executes and the single result transaction appears on o_valid in the
// following cycle, when the next operation can already be started. Delete
// all removes one matching entry per cycle in the cell chain and stays busy
// until none is left. Results cannot be held off: o_valid is high for exactly
// one cycle per operation.
module sorted_key_queue
    import skq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_opcode,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic                i_cfg_data,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [KEY_BITS-1:0] o_out_key,
    output logic [TAG_BITS-1:0] o_out_tag,
    output logic [5:0]          o_count
);
    t_cmd  cmd;
    t_stat stat;

    skq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    skq_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opcode  (i_opcode),
        .i_key     (i_key),
        .i_tag     (i_tag),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_out_key (o_out_key),
        .o_out_tag (o_out_tag),
        .o_count   (o_count)
    );
endmodule

[hdl/skq_datapath.sv]
// Sorted entry cells with per-cell compare, fill count and result registers.
`include "assert_macros.svh"
module skq_datapath
    import skq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_opcode,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [KEY_BITS-1:0] o_out_key,
    output logic [TAG_BITS-1:0] o_out_tag,
    output logic [5:0]          o_count
);
    localparam int FW = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0] r_keys [DEPTH];
    logic [TAG_BITS-1:0] r_tags [DEPTH];
    logic [KEY_BITS-1:0] n_keys [DEPTH];
    logic [TAG_BITS-1:0] n_tags [DEPTH];
    logic [FW-1:0]       r_fill, n_fill;
    logic [FW-1:0]       r_removed;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_k;
    logic [TAG_BITS-1:0] r_t;

    logic [DEPTH-1:0] valid, match, first, lower, shift;
    logic [TAG_BITS-1:0] match_tag;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign valid[g]  = (FW'(g) < r_fill);
            assign match[g]  = valid[g] && (r_keys[g] == r_k);
            assign lower[g]  = valid[g] && (i_cmd.append ? (r_keys[g] <= r_k)
                                                         : (r_keys[g] < r_k));
            // Equal keys sit together, so the first match is where a run starts.
            assign shift[g]  = i_cmd.rm_head ||
                               (i_cmd.rm_match && valid[g] && (r_keys[g] >= r_k));
            if (g == 0) begin : g_head
                assign first[g] = match[g];
                always_comb begin
                    n_keys[g] = r_keys[g];
                    n_tags[g] = r_tags[g];
                    if (i_cmd.ins) begin
                        if (!lower[g]) begin
                            n_keys[g] = r_k;
                            n_tags[g] = r_t;
                        end
                    end else if (shift[g] && DEPTH > 1) begin
                        n_keys[g] = r_keys[(g + 1) % DEPTH];
                        n_tags[g] = r_tags[(g + 1) % DEPTH];
                    end
                end
            end else begin : g_body
                assign first[g] = match[g] && !match[g-1];
                always_comb begin
                    n_keys[g] = r_keys[g];
                    n_tags[g] = r_tags[g];
                    if (i_cmd.ins) begin
                        if (!lower[g]) begin
                            if (lower[g-1]) begin
                                n_keys[g] = r_k;
                                n_tags[g] = r_t;
                            end else begin
                                n_keys[g] = r_keys[g-1];
                                n_tags[g] = r_tags[g-1];
                            end
                        end
                    end else if (shift[g] && g < DEPTH - 1) begin
                        n_keys[g] = r_keys[(g + 1) % DEPTH];
                        n_tags[g] = r_tags[(g + 1) % DEPTH];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        match_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match_tag = match_tag | (r_tags[i] & {TAG_BITS{first[i]}});
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.clr) begin
            n_fill = '0;
        end else if (i_cmd.ins) begin
            n_fill = r_fill + 1'b1;
        end else if (i_cmd.rm_head || i_cmd.rm_match) begin
            n_fill = r_fill - 1'b1;
        end
    end

    assign o_stat.op           = r_op;
    assign o_stat.any_match    = |match;
    assign o_stat.full         = (r_fill == FW'(DEPTH));
    assign o_stat.empty        = (r_fill == '0);
    assign o_stat.removed_zero = (r_removed == '0);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_keys[i] <= n_keys[i];
            r_tags[i] <= n_tags[i];
        end
        if (i_cmd.load) begin
            r_op <= t_op'(i_opcode);
            r_k  <= i_key;
            r_t  <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_removed <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            o_valid <= i_cmd.res_we;
            if (i_cmd.load) begin
                r_removed <= '0;
            end else if (i_cmd.rm_match) begin
                r_removed <= r_removed + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            o_status <= i_cmd.status;
            if (i_cmd.cnt_removed) begin
                o_count <= sat_count(CNT_IN_W'(r_removed) + CNT_IN_W'(i_cmd.rm_match));
            end else begin
                o_count <= sat_count(CNT_IN_W'(n_fill));
            end
            case (i_cmd.osel)
                OSEL_HEAD: begin
                    o_out_key <= r_keys[0];
                    o_out_tag <= r_tags[0];
                end
                OSEL_MATCH: begin
                    o_out_key <= r_k;
                    o_out_tag <= match_tag;
                end
                default: begin
                    o_out_key <= '0;
                    o_out_tag <= '0;
                end
            endcase
        end
    end

    `SKQ_ASSERT_ALWAYS(a_fill_bound, r_fill <= FW'(DEPTH))
    `SKQ_ASSERT_NEXT(a_clear_empties, i_cmd.clr, r_fill == '0)
    `SKQ_ASSERT_NEXT(a_insert_grows, i_cmd.ins, r_fill == FW'($past(r_fill) + 1'b1))
    `SKQ_ASSERT_ALWAYS(a_one_update,
        $onehot0({i_cmd.ins, i_cmd.rm_head, i_cmd.rm_match, i_cmd.clr}))
endmodule

[hdl/skq_ctrl.sv]
// Operation sequencer and duplicate policy registers for the sorted key queue.
module skq_ctrl
    import skq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  logic  i_cfg_we,
    input  logic  i_cfg_idx,
    input  logic  i_cfg_data,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state r_state, n_state;
    logic   r_allow, r_append;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd             = '0;
        o_cmd.append      = r_append;
        o_cmd.status      = ST_OK;
        o_cmd.osel        = OSEL_NONE;
        n_state           = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.res_we = 1'b1;
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!r_allow && i_stat.any_match) begin
                            o_cmd.status = ST_DUP;
                        end else if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.ins = 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_MISS;
                        end else begin
                            o_cmd.osel    = OSEL_HEAD;
                            o_cmd.rm_head = (i_stat.op == OP_POP);
                        end
                    end
                    OP_FIND: begin
                        if (i_stat.any_match) begin
                            o_cmd.osel = OSEL_MATCH;
                        end else begin
                            o_cmd.status = ST_MISS;
                        end
                    end
                    OP_DEL_FIRST: begin
                        o_cmd.cnt_removed = 1'b1;
                        if (i_stat.any_match) begin
                            o_cmd.rm_match = 1'b1;
                        end else begin
                            o_cmd.status = ST_MISS;
                        end
                    end
                    OP_DEL_ALL: begin
                        o_cmd.cnt_removed = 1'b1;
                        // One matching entry leaves per cycle until none is left.
                        if (i_stat.any_match) begin
                            o_cmd.rm_match = 1'b1;
                            o_cmd.res_we   = 1'b0;
                        end else if (i_stat.removed_zero) begin
                            o_cmd.status = ST_MISS;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clr = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (o_cmd.res_we) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_allow  <= 1'b1;
            r_append <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ALLOW_DUPS) begin
                    r_allow <= i_cfg_data;
                end else begin
                    r_append <= i_cfg_data;
                end
            end
        end
    end
endmodule
